// File: hw/rtl/vmbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmbd_pkg
// Shared types and constants of the video memory bus decoder.
// ----------------------------------------------------------------------------
package vmbd_pkg;

  localparam int unsigned BANK_WORDS    = 1024;
  localparam int unsigned PALETTE_WORDS = 32;
  localparam int unsigned NT_WORDS      = 2 * BANK_WORDS;
  localparam int unsigned NT_AW         = $clog2(NT_WORDS);
  localparam int unsigned BANK_AW       = $clog2(BANK_WORDS);
  localparam int unsigned PAL_AW        = $clog2(PALETTE_WORDS);

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned WRAP_W   = 14;
  localparam int unsigned CADDR_W  = 13;
  localparam int unsigned CACC_W   = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned IN_TD_W  = 32;
  localparam int unsigned OUT_TD_W = 32;

  localparam logic [WRAP_W-1:0] PAT_LAST = 14'h1FFF;
  localparam logic [WRAP_W-1:0] NT_LAST  = 14'h3EFF;

  localparam logic [MODE_W-1:0] MIRROR_VERT  = 2'd0;
  localparam logic [MODE_W-1:0] MIRROR_HORIZ = 2'd1;

  localparam logic [CACC_W-1:0] CART_NONE  = 2'd0;
  localparam logic [CACC_W-1:0] CART_READ  = 2'd1;
  localparam logic [CACC_W-1:0] CART_WRITE = 2'd2;

  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [1:0] {
    RGN_PATTERN = 2'd0,
    RGN_NAMETBL = 2'd1,
    RGN_PALETTE = 2'd2
  } region_t;

  typedef struct packed {
    logic load;    // capture input word and decode
    logic access;  // perform memory access
    logic store;   // register result word
  } vmbd_cmd_t;

endpackage : vmbd_pkg
`default_nettype wire

// File: hw/rtl/vmbd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmbd_ctrl
// Sequencer: accept a word, run the memory access, fill the output register.
// ----------------------------------------------------------------------------
module vmbd_ctrl import vmbd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output vmbd_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ACCESS = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   store;

  // output register free or being drained this cycle
  assign store = (state_r == ST_RESULT) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (store) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (store) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.access = (state_r == ST_ACCESS);
  assign cmd.store  = store;

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> out_tvalid)
    else $error("result word stored but not presented");

  a_access_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.access |-> $past(cmd.load))
    else $error("memory access without a loaded word");

  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped before accept");

endmodule : vmbd_ctrl
`default_nettype wire

// File: hw/rtl/vmbd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmbd_dp
// Address decode, name table and palette RAMs, result assembly.
// ----------------------------------------------------------------------------
module vmbd_dp import vmbd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire vmbd_cmd_t            cmd,
  input  wire logic                 cfg_we,
  input  wire logic [MODE_W-1:0]    cfg_mode,
  input  wire logic                 func,
  input  wire logic [ADDR_W-1:0]    address,
  input  wire logic [DATA_W-1:0]    write_data,
  input  wire logic [DATA_W-1:0]    cart_read_data,
  output logic      [DATA_W-1:0]    read_data,
  output logic      [CACC_W-1:0]    cart_access,
  output logic      [CADDR_W-1:0]   cart_address,
  output logic      [DATA_W-1:0]    cart_write_data
);

  logic [MODE_W-1:0]  mode_r;
  logic [DATA_W-1:0]  nt_mem  [NT_WORDS];
  logic [DATA_W-1:0]  pal_mem [PALETTE_WORDS];

  logic               wr_r;
  region_t            rgn_r;
  logic               mapped_r;
  logic [NT_AW-1:0]   nt_idx_r;
  logic [PAL_AW-1:0]  pal_idx_r;
  logic [CADDR_W-1:0] caddr_r;
  logic [DATA_W-1:0]  wdata_r;
  logic [DATA_W-1:0]  cdata_r;
  logic [DATA_W-1:0]  nt_q_r;
  logic [DATA_W-1:0]  pal_q_r;

  logic [DATA_W-1:0]  rdata_r,  rdata_nxt;
  logic [CACC_W-1:0]  cacc_r,   cacc_nxt;
  logic [CADDR_W-1:0] cart_a_r, cart_a_nxt;
  logic [DATA_W-1:0]  cwdata_r, cwdata_nxt;

  logic [WRAP_W-1:0]  wa;
  region_t            rgn;
  logic               bank;
  logic [PAL_AW-1:0]  pal_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MIRROR_VERT;
    end else if (cfg_we) begin
      mode_r <= cfg_mode;
    end
  end

  always_comb begin
    wa = address[WRAP_W-1:0];
    if (wa <= PAT_LAST) begin
      rgn = RGN_PATTERN;
    end else if (wa <= NT_LAST) begin
      rgn = RGN_NAMETBL;
    end else begin
      rgn = RGN_PALETTE;
    end
    bank    = (mode_r == MIRROR_VERT) ? wa[BANK_AW] : wa[BANK_AW+1];
    pal_idx = wa[PAL_AW-1:0];
    // mirrored backdrop entries
    if (pal_idx[PAL_AW-1] && (pal_idx[1:0] == 2'b00)) pal_idx[PAL_AW-1] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wr_r      <= (func == FUNC_WRITE);
      rgn_r     <= rgn;
      mapped_r  <= (mode_r == MIRROR_VERT) || (mode_r == MIRROR_HORIZ);
      nt_idx_r  <= {bank, wa[BANK_AW-1:0]};
      pal_idx_r <= pal_idx;
      caddr_r   <= wa[CADDR_W-1:0];
      wdata_r   <= write_data;
      cdata_r   <= cart_read_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      if (wr_r && (rgn_r == RGN_NAMETBL) && mapped_r) nt_mem[nt_idx_r] <= wdata_r;
      nt_q_r <= nt_mem[nt_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      if (wr_r && (rgn_r == RGN_PALETTE)) pal_mem[pal_idx_r] <= wdata_r;
      pal_q_r <= pal_mem[pal_idx_r];
    end
  end

  always_comb begin
    rdata_nxt  = '0;
    cacc_nxt   = CART_NONE;
    cart_a_nxt = '0;
    cwdata_nxt = '0;
    case (rgn_r)
      RGN_PATTERN: begin
        cart_a_nxt = caddr_r;
        if (wr_r) begin
          cacc_nxt   = CART_WRITE;
          cwdata_nxt = wdata_r;
        end else begin
          cacc_nxt  = CART_READ;
          rdata_nxt = cdata_r;
        end
      end
      RGN_NAMETBL: begin
        if (!wr_r && mapped_r) rdata_nxt = nt_q_r;
      end
      RGN_PALETTE: begin
        if (!wr_r) rdata_nxt = pal_q_r;
      end
      default: begin
        rdata_nxt = '0;
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rdata_r  <= rdata_nxt;
      cacc_r   <= cacc_nxt;
      cart_a_r <= cart_a_nxt;
      cwdata_r <= cwdata_nxt;
    end
  end

  assign read_data       = rdata_r;
  assign cart_access     = cacc_r;
  assign cart_address    = cart_a_r;
  assign cart_write_data = cwdata_r;

endmodule : vmbd_dp
`default_nettype wire

// File: hw/rtl/video_memory_bus_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// video_memory_bus_decoder_unit
// Video bus decoder: pattern space to cartridge, mirrored name tables, palette.
// ----------------------------------------------------------------------------
// One bus word is decoded at a time: after accept the word is captured and
// decoded, the single-port name table and palette RAMs are accessed
// synchronously and the result is loaded into the output register. A new
// word is taken only once that result is loaded. The output register lets
// the next word run while a result waits on out_tready; the input is not
// ready while a word is in flight, and a result waits to load while the
// output register is still full. Mirroring mode is written through the cfg
// channel, which is always ready, and must only change while no word is in
// flight. Name table and palette entries must be written before they are read.
module video_memory_bus_decoder_unit import vmbd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // address[15:0], write_data[23:16], cart_read_data[31:24]
  input  wire logic [IN_TD_W-1:0]    in_tdata,
  // func[0]
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // read_data[7:0], cart_address[20:8], cart_write_data[28:21], zero[31:29]
  output logic      [OUT_TD_W-1:0]   out_tdata,
  // cart_access[1:0]
  output logic      [CACC_W-1:0]     out_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [MODE_W-1:0]     cfg_data
);

  vmbd_cmd_t          cmd;
  logic [DATA_W-1:0]  read_data;
  logic [CADDR_W-1:0] cart_address;
  logic [DATA_W-1:0]  cart_write_data;

  assign cfg_ready = 1'b1;

  vmbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  vmbd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_mode        (cfg_data),
    .func            (in_tuser),
    .address         (in_tdata[15:0]),
    .write_data      (in_tdata[23:16]),
    .cart_read_data  (in_tdata[31:24]),
    .read_data       (read_data),
    .cart_access     (out_tuser),
    .cart_address    (cart_address),
    .cart_write_data (cart_write_data)
  );

  assign out_tdata = {3'b000, cart_write_data, cart_address, read_data};

endmodule : video_memory_bus_decoder_unit
`default_nettype wire

// File: tb/sv/tb_video_memory_bus_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_video_memory_bus_decoder_unit
// Self-checking bench for the video memory bus decoder. Drives bus words
// (directed edge addresses, then mostly random reads and writes over the
// pattern, name table and palette spaces) under every mirroring mode, with
// random stalls on both sides. A scoreboard tracks name table and palette
// contents and checks each result word field by field.
// ----------------------------------------------------------------------------
module tb_video_memory_bus_decoder_unit import vmbd_pkg::*; ();

  localparam logic               FUNC_READ     = 1'b0;
  localparam logic [MODE_W-1:0]  MIRROR_OFF    = 2'd2;
  localparam logic [MODE_W-1:0]  MIRROR_OFF_HI = 2'd3;
  localparam logic [WRAP_W-1:0]  NT_FIRST      = 14'h2000;
  localparam logic [WRAP_W-1:0]  PAL_FIRST     = 14'h3F00;
  localparam logic [WRAP_W-1:0]  PAL_LAST      = 14'h3FFF;
  localparam int                 DRAIN_CYCLES  = 8;
  localparam int                 SEG_WORDS     = 115;
  localparam int                 CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [CACC_W-1:0]  cart_access;
    logic [CADDR_W-1:0] cart_address;
    logic [DATA_W-1:0]  cart_write_data;
  } bus_result_t;

  // tracks memory contents and the results owed by the block
  class vmbd_decode_tracker;
    logic [MODE_W-1:0] mirror_mode = MIRROR_VERT;
    logic [DATA_W-1:0] nt_ram [NT_WORDS];
    bit                nt_written [NT_WORDS];
    logic [DATA_W-1:0] pal_ram [PALETTE_WORDS];
    bit                pal_written [PALETTE_WORDS];
    bus_result_t       due_results [$];
    int                errors = 0;
    int                n_results = 0;
    int                n_pattern = 0;
    int                n_nametbl = 0;
    int                n_palette = 0;

    function automatic bit nt_slot(logic [WRAP_W-1:0] wa, output int idx);
      logic [11:0] ofs;
      logic        bank;
      ofs = wa[11:0];
      idx = 0;
      case (mirror_mode)
        MIRROR_VERT:  bank = ofs[10];
        MIRROR_HORIZ: bank = ofs[11];
        default:      return 1'b0;
      endcase
      idx = int'(bank) * BANK_WORDS + int'(ofs[9:0]);
      return 1'b1;
    endfunction

    function automatic int pal_slot(logic [WRAP_W-1:0] wa);
      logic [4:0] e;
      e = wa[4:0];
      // mirrored backdrop entries fold onto the low half
      if (e[4] && e[1:0] == 2'b00) e[4] = 1'b0;
      return int'(e);
    endfunction

    // a read here would not touch a never-written entry
    function automatic bit readable(logic [ADDR_W-1:0] a);
      logic [WRAP_W-1:0] wa;
      int                idx;
      wa = a[WRAP_W-1:0];
      if (wa <= PAT_LAST) return 1'b1;
      if (wa <= NT_LAST) begin
        if (!nt_slot(wa, idx)) return 1'b1;
        return nt_written[idx];
      end
      return pal_written[pal_slot(wa)];
    endfunction

    function automatic void note_access(logic f, logic [ADDR_W-1:0] a,
                                        logic [DATA_W-1:0] wd, logic [DATA_W-1:0] crd);
      logic [WRAP_W-1:0] wa;
      bus_result_t       r;
      int                idx;
      wa = a[WRAP_W-1:0];
      r  = '0;
      if (wa <= PAT_LAST) begin
        n_pattern++;
        r.cart_address = wa[CADDR_W-1:0];
        if (f == FUNC_WRITE) begin
          r.cart_access     = CART_WRITE;
          r.cart_write_data = wd;
        end else begin
          r.cart_access = CART_READ;
          r.read_data   = crd;
        end
      end else if (wa <= NT_LAST) begin
        n_nametbl++;
        if (nt_slot(wa, idx)) begin
          if (f == FUNC_WRITE) begin
            nt_ram[idx]     = wd;
            nt_written[idx] = 1'b1;
          end else begin
            r.read_data = nt_ram[idx];
          end
        end
      end else begin
        n_palette++;
        idx = pal_slot(wa);
        if (f == FUNC_WRITE) begin
          pal_ram[idx]     = wd;
          pal_written[idx] = 1'b1;
        end else begin
          r.read_data = pal_ram[idx];
        end
      end
      due_results.push_back(r);
    endfunction

    function automatic void check_result(logic [OUT_TD_W-1:0] td, logic [CACC_W-1:0] tu);
      bus_result_t e;
      n_results++;
      if (due_results.size() == 0) begin
        $error("result word with none outstanding: tdata=%h tuser=%h", td, tu);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (td[7:0] !== e.read_data) begin
        $error("read_data: expected %h, got %h", e.read_data, td[7:0]);
        errors++;
      end
      if (tu !== e.cart_access) begin
        $error("cart_access: expected %0d, got %0d", e.cart_access, tu);
        errors++;
      end
      if (td[20:8] !== e.cart_address) begin
        $error("cart_address: expected %h, got %h", e.cart_address, td[20:8]);
        errors++;
      end
      if (td[28:21] !== e.cart_write_data) begin
        $error("cart_write_data: expected %h, got %h", e.cart_write_data, td[28:21]);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;
  logic [CACC_W-1:0]   out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MODE_W-1:0]   cfg_data = '0;

  vmbd_decode_tracker sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int cycle_count = 0;
  int n_cfg = 0;

  video_memory_bus_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               sb.due_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check, then pick next ready; one long hold to back up the block
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!held_once && sb.n_results == 150) begin
      out_tready <= 1'b0;
      hold_left  <= 300;
      held_once  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_word(logic f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] wd,
                           logic [DATA_W-1:0] crd);
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {crd, wd, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_access(f, a, wd, crd);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mirroring(logic [MODE_W-1:0] m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    sb.mirror_mode  = m;
    n_cfg++;
  endtask

  initial begin
    logic [MODE_W-1:0] seg_modes [6];
    logic              f;
    logic [WRAP_W-1:0] wa;
    logic [ADDR_W-1:0] a;
    logic [WRAP_W-1:0] recent_wa [$];
    int                pick;

    seg_modes = '{MIRROR_HORIZ, MIRROR_VERT, MIRROR_OFF, MIRROR_OFF_HI, MIRROR_HORIZ,
                  MIRROR_VERT};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: space boundaries, address wrap, palette folding, mirroring
    set_mirroring(MIRROR_VERT);
    send_word(FUNC_WRITE, 16'h0000, 8'hFF, 8'h00);
    send_word(FUNC_READ,  16'h1FFF, 8'h00, 8'hFF);
    send_word(FUNC_READ,  16'hC000, 8'hFF, 8'h00);
    send_word(FUNC_WRITE, 16'h9FFF, 8'h00, 8'hFF);
    send_word(FUNC_WRITE, 16'h3F10, 8'h3C, 8'h00);
    send_word(FUNC_READ,  16'h3F00, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 16'h3F1C, 8'h81, 8'h00);
    send_word(FUNC_READ,  16'h3F0C, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 16'h3F04, 8'h11, 8'h00);
    send_word(FUNC_READ,  16'h3F14, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 16'h3FFF, 8'hA5, 8'h00);
    send_word(FUNC_READ,  16'hFFFF, 8'h00, 8'hFF);
    send_word(FUNC_WRITE, 16'h2000, 8'h5A, 8'h00);
    send_word(FUNC_READ,  16'h2800, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 16'h3EFF, 8'hFF, 8'h00);
    send_word(FUNC_READ,  16'h36FF, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 16'h2400, 8'h00, 8'h00);
    send_word(FUNC_READ,  16'h6400, 8'h00, 8'h00);
    set_mirroring(MIRROR_HORIZ);
    send_word(FUNC_WRITE, 16'h2C00, 8'h77, 8'h00);
    send_word(FUNC_READ,  16'h2800, 8'h00, 8'h00);
    set_mirroring(MIRROR_OFF);
    send_word(FUNC_READ,  16'h2000, 8'h00, 8'h00);
    send_word(FUNC_WRITE, 16'h2000, 8'h99, 8'h00);
    set_mirroring(MIRROR_OFF_HI);
    send_word(FUNC_READ,  16'h3EFF, 8'h00, 8'h00);
    set_mirroring(MIRROR_VERT);
    send_word(FUNC_READ,  16'h2000, 8'h00, 8'h00);

    // random segments, one mirroring mode each
    for (int s = 0; s < 6; s++) begin
      set_mirroring(seg_modes[s]);
      tx_idle_pct = (s < 2) ? 38 : (s < 4) ? 45 : 0;
      rx_idle_pct = (s < 2) ? 45 : (s < 4) ? 38 : 0;
      for (int i = 0; i < SEG_WORDS; i++) begin
        if (s == 2 && i == SEG_WORDS / 2) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.due_results.size() != 0) @(posedge clk);
        end
        pick = $urandom_range(0, 99);
        f    = 1'($urandom_range(0, 1));
        if (pick < 30) wa = 14'($urandom_range(0, PAT_LAST));
        else if (pick < 70) wa = 14'($urandom_range(NT_FIRST, NT_LAST));
        else wa = 14'($urandom_range(PAL_FIRST, PAL_LAST));
        // reads often revisit recently written entries
        if (pick >= 30 && f == FUNC_READ && recent_wa.size() > 0 && $urandom_range(0, 1))
          wa = recent_wa[$urandom_range(0, recent_wa.size() - 1)];
        a = {2'($urandom_range(0, 3)), wa};
        if (f == FUNC_READ && !sb.readable(a)) f = FUNC_WRITE;
        if (f == FUNC_WRITE && wa > PAT_LAST) begin
          recent_wa.push_back(wa);
          if (recent_wa.size() > 16) void'(recent_wa.pop_front());
        end
        send_word(f, a, 8'($urandom), 8'($urandom));
      end
    end

    wait_drained();
    $display("covered %0d pattern, %0d name table and %0d palette words; %0d results checked",
             sb.n_pattern, sb.n_nametbl, sb.n_palette, sb.n_results);
    $display("%0d mirroring writes over modes 0-3, both-side stalls and a long output hold",
             n_cfg);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/vmbd_pkg.sv
hw/rtl/vmbd_ctrl.sv
hw/rtl/vmbd_dp.sv
hw/rtl/video_memory_bus_decoder_unit.sv
tb/sv/tb_video_memory_bus_decoder_unit.sv
